### sv/lksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksd_pkg
// Shared types and codes for the LED display / key scan device logic.
// ----------------------------------------------------------------------------
package lksd_pkg;

    // bus event carried in tuser on the input side
    localparam logic [1:0] EV_WRITE = 2'd0;
    localparam logic [1:0] EV_READ  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    // command class in bits 7..6 of the first byte of a frame
    localparam logic [1:0] KIND_NONE    = 2'b00;
    localparam logic [1:0] KIND_DATA    = 2'b01;
    localparam logic [1:0] KIND_DISPLAY = 2'b10;
    localparam logic [1:0] KIND_ADDRESS = 2'b11;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int LEVEL_W  = 3;
    localparam int KEY_W    = 32;
    localparam int KIDX_W   = 3;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    // one classified word travelling from front to back
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               ram_write;
        logic [ADDR_W-1:0]  ram_addr;
        logic [DATA_W-1:0]  ram_data;
        logic               display_on;
        logic [LEVEL_W-1:0] brightness;
        logic [1:0]         status;
    } lksd_op_t;

endpackage

### sv/lksd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksd_front
// Accepts bus events, decodes commands and keeps the frame, address, key
// and display control state; emits one classified result word per event.
// ----------------------------------------------------------------------------
module lksd_front #(
    parameter int DISPLAY_REGS = 16,
    parameter int KEY_BYTES    = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                in_cmd,
    input  logic [lksd_pkg::DATA_W-1:0] in_byte,
    input  logic [lksd_pkg::KEY_W-1:0]  in_keys,
    output logic                      op_valid,
    input  logic                      op_ready,
    output lksd_pkg::lksd_op_t        op
);
    import lksd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DISPLAY_REGS - 1);
    localparam logic [KIDX_W-1:0] KEY_END   = KIDX_W'(KEY_BYTES);

    logic                      frame_first_reg, frame_first_next;
    logic                      read_mode_reg, read_mode_next;
    logic [ADDR_W-1:0]         addr_ptr_reg, addr_ptr_next;
    logic [KIDX_W-1:0]         key_index_reg, key_index_next;
    logic [3:0][DATA_W-1:0]    key_latch_reg, key_latch_next;
    logic                      disp_enable_reg, disp_enable_next;
    logic [LEVEL_W-1:0]        bright_reg, bright_next;
    logic [ADDR_W-1:0]         sat_addr;
    logic                      accept;

    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign accept   = in_valid & op_ready;

    always_comb
    begin
        sat_addr = in_byte[ADDR_W-1:0];
        if (sat_addr > ADDR_LAST)
        begin
            sat_addr = ADDR_LAST;
        end
    end

    always_comb
    begin
        frame_first_next = frame_first_reg;
        read_mode_next   = read_mode_reg;
        addr_ptr_next    = addr_ptr_reg;
        key_index_next   = key_index_reg;
        key_latch_next   = key_latch_reg;
        disp_enable_next = disp_enable_reg;
        bright_next      = bright_reg;
        op               = '0;
        op.status        = ST_OK;

        unique case (in_cmd)
            EV_WRITE:
            begin
                if (frame_first_reg)
                begin
                    frame_first_next = 1'b0;
                    unique case (in_byte[7:6])
                        KIND_DATA:
                        begin
                            read_mode_next = in_byte[1];
                            if (in_byte[1])
                            begin
                                key_latch_next = in_keys;
                                key_index_next = '0;
                            end
                        end
                        KIND_DISPLAY:
                        begin
                            disp_enable_next = in_byte[3];
                            bright_next      = in_byte[LEVEL_W-1:0];
                        end
                        KIND_ADDRESS:
                        begin
                            addr_ptr_next = sat_addr;
                        end
                        default:
                        begin
                            op.status = ST_IGNORED;
                        end
                    endcase
                end
                else if (read_mode_reg)
                begin
                    op.status = ST_IGNORED;
                end
                else
                begin
                    op.ram_write  = 1'b1;
                    op.ram_addr   = addr_ptr_reg;
                    op.ram_data   = in_byte;
                    addr_ptr_next = (addr_ptr_reg >= ADDR_LAST) ? '0 : addr_ptr_reg + 1'b1;
                end
            end
            EV_READ:
            begin
                if (frame_first_reg || !read_mode_reg)
                begin
                    op.status = ST_IGNORED;
                end
                else if (key_index_reg < KEY_END)
                begin
                    op.read_data   = key_latch_reg[key_index_reg[1:0]];
                    key_index_next = key_index_reg + 1'b1;
                end
                else
                begin
                    op.status = ST_OVERRUN;
                end
            end
            EV_END:
            begin
                frame_first_next = 1'b1;
            end
            default:
            begin
                op.status = ST_IGNORED;
            end
        endcase

        // display control reported as it stands after this word
        op.display_on = disp_enable_next;
        op.brightness = bright_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_first_reg <= 1'b1;
            read_mode_reg   <= 1'b0;
            addr_ptr_reg    <= '0;
            key_index_reg   <= '0;
            key_latch_reg   <= '0;
            disp_enable_reg <= 1'b0;
            bright_reg      <= '0;
        end
        else if (accept)
        begin
            frame_first_reg <= frame_first_next;
            read_mode_reg   <= read_mode_next;
            addr_ptr_reg    <= addr_ptr_next;
            key_index_reg   <= key_index_next;
            key_latch_reg   <= key_latch_next;
            disp_enable_reg <= disp_enable_next;
            bright_reg      <= bright_next;
        end
    end

endmodule

### sv/lksd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksd_queue
// Two-entry FIFO of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module lksd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lksd_pkg::lksd_op_t push_op,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lksd_pkg::lksd_op_t pop_op
);
    import lksd_pkg::*;

    lksd_op_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### sv/lksd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lksd_back
// Drains the queue into the output register and packs the result word.
// ----------------------------------------------------------------------------
module lksd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      op_valid,
    output logic                      op_ready,
    input  lksd_pkg::lksd_op_t        op,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lksd_pkg::OUT_W-1:0] out_data,
    output logic [1:0]                out_user
);
    import lksd_pkg::*;

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg, data_next;
    logic [1:0]       user_reg, user_next;
    logic             load;

    // load when the output stage is empty or being emptied this cycle
    assign op_ready = ~valid_reg | out_ready;
    assign load     = op_valid & op_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        if (op_ready)
        begin
            valid_next = op_valid;
        end
        if (load)
        begin
            data_next = {7'd0, op.brightness, op.display_on, op.ram_data,
                         op.ram_addr, op.ram_write, op.read_data};
            user_next = op.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

### sv/led_key_scan_display_slave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_key_scan_display_slave
// Device side of a strobe-framed serial LED display and key scan controller.
// ----------------------------------------------------------------------------
// Input stream: one word per bus event (byte written, byte read, frame end),
// event code in tuser, host byte and current key matrix in tdata. Output
// stream: one result word per input word, in order, carrying the key byte
// read, the display register write (address, data), the display enable and
// brightness after the event, and a status code in tuser.
// Throughput is one word per cycle while the queue has room: the front
// decoder updates all frame and display state in the cycle a word is
// taken and pushes a result into a two-entry queue, which the output
// register drains. An accepted word's result is written into the queue
// and then loaded into the output register, which drives the output.
// When the receiver stalls, results collect in the output register and the
// queue; s_axis_tready falls only once both are full, and nothing is lost.
// Reset clears the queue and output valid, returns the decoder to "next
// byte is a command" in write mode, address zero, display off, level zero.
// The display registers themselves live downstream and are fed from the
// reported writes.
// ----------------------------------------------------------------------------
module led_key_scan_display_slave #(
    parameter int DISPLAY_REGS = 16,
    parameter int KEY_BYTES    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] data_byte, [39:8] key_bits
    input  logic [lksd_pkg::IN_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] read_data, [8] ram_write, [12:9] ram_addr, [20:13] ram_data,
    // [21] display_on, [24:22] brightness, [31:25] zero
    output logic [lksd_pkg::OUT_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]                 m_axis_tuser
);
    import lksd_pkg::*;

    lksd_op_t front_op, back_op;
    logic     front_valid, front_ready;
    logic     back_valid, back_ready;

    lksd_front #(
        .DISPLAY_REGS (DISPLAY_REGS),
        .KEY_BYTES    (KEY_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_byte  (s_axis_tdata[DATA_W-1:0]),
        .in_keys  (s_axis_tdata[IN_W-1:DATA_W]),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    lksd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    lksd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (back_valid),
        .op_ready  (back_ready),
        .op        (back_op),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

### tb/led_key_scan_display_slave_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_key_scan_display_slave_tb
// Self-checking bench for the LED display / key scan device logic.
// ----------------------------------------------------------------------------
// A queue of bus events (byte written, byte read, frame end) is filled by
// a directed opening and then by random frames: data, address, display
// control and key read frames with random content, plus loose noise. A
// falling-edge driver feeds the input stream. A rising-edge monitor keeps
// a shadow of the frame and display state, predicts one result word per
// accepted event, and compares every result word field by field. Sender
// gaps and receiver stalls change over four phases.
// ----------------------------------------------------------------------------
module led_key_scan_display_slave_tb;

    import lksd_pkg::*;

    localparam int NUM_REGS   = 16;
    localparam int NUM_KEYS   = 4;
    localparam int RAND_WORDS = 800;
    localparam int MAX_CYCLES = 200000;
    localparam int MAX_SHOWN  = 10;

    // unused event code, must be ignored by the device
    localparam logic [1:0] EV_RSVD = 2'd3;

    typedef struct {
        logic [1:0]  ev;
        logic [7:0]  data_byte;
        logic [31:0] keys;
        int unsigned phase;
    } host_event_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = EV_WRITE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    host_event_t         host_events[$];
    lksd_op_t            expected_results[$];
    logic                in_taken = 1'b0;
    int unsigned         cur_phase = 0;
    int unsigned         words_made = 0;
    int unsigned         fail_count = 0;
    int unsigned         cycle_count = 0;

    // shadow of the device state
    logic                dev_frame_first = 1'b1;
    logic                dev_read_mode = 1'b0;
    logic [3:0]          dev_addr_ptr = '0;
    logic [2:0]          dev_key_index = '0;
    logic [31:0]         dev_key_latch = '0;
    logic                dev_disp_on = 1'b0;
    logic [2:0]          dev_level = '0;

    led_key_scan_display_slave #(
        .DISPLAY_REGS (NUM_REGS),
        .KEY_BYTES    (NUM_KEYS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic int unsigned send_idle_pct(input int unsigned ph);
        return (ph == 1) ? 51 : (ph == 3) ? 26 : 0;
    endfunction

    function automatic int unsigned recv_stall_pct(input int unsigned ph);
        return (ph == 2) ? 51 : (ph == 3) ? 26 : 0;
    endfunction

    // Works out the result word of one bus event and advances the shadow.
    function automatic lksd_op_t predict_bus_event(input logic [1:0] ev,
                                                   input logic [7:0] b,
                                                   input logic [31:0] keys);
        lksd_op_t r;
        logic [3:0] a;
        r = '0;
        r.status = ST_OK;
        case (ev)
            EV_WRITE:
            begin
                if (dev_frame_first)
                begin
                    dev_frame_first = 1'b0;
                    case (b[7:6])
                        KIND_DATA:
                        begin
                            dev_read_mode = b[1];
                            if (b[1])
                            begin
                                dev_key_latch = keys;
                                dev_key_index = '0;
                            end
                        end
                        KIND_DISPLAY:
                        begin
                            dev_disp_on = b[3];
                            dev_level   = b[2:0];
                        end
                        KIND_ADDRESS:
                        begin
                            a = b[3:0];
                            if (a > NUM_REGS - 1)
                                a = 4'(NUM_REGS - 1);
                            dev_addr_ptr = a;
                        end
                        default:
                            r.status = ST_IGNORED;
                    endcase
                end
                else if (dev_read_mode)
                begin
                    r.status = ST_IGNORED;
                end
                else
                begin
                    r.ram_write  = 1'b1;
                    r.ram_addr   = dev_addr_ptr;
                    r.ram_data   = b;
                    dev_addr_ptr = (dev_addr_ptr >= NUM_REGS - 1) ? 4'd0 : dev_addr_ptr + 4'd1;
                end
            end
            EV_READ:
            begin
                if (dev_frame_first || !dev_read_mode)
                    r.status = ST_IGNORED;
                else if (dev_key_index < NUM_KEYS)
                begin
                    r.read_data   = 8'(dev_key_latch >> (8 * dev_key_index[1:0]));
                    dev_key_index = dev_key_index + 3'd1;
                end
                else
                    r.status = ST_OVERRUN;
            end
            EV_END:
                dev_frame_first = 1'b1;
            default:
                r.status = ST_IGNORED;
        endcase
        r.display_on = dev_disp_on;
        r.brightness = dev_level;
        return r;
    endfunction

    task automatic add_event(input logic [1:0] ev, input logic [7:0] b,
                             input logic [31:0] keys, input int unsigned ph);
        host_event_t e;
        e.ev        = ev;
        e.data_byte = b;
        e.keys      = keys;
        e.phase     = ph;
        host_events.push_back(e);
        words_made++;
    endtask

    // driver: inputs move on the falling edge
    always @(negedge clk)
    begin
        host_event_t e;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct(cur_phase));
            if (!s_axis_tvalid || in_taken)
            begin
                if (host_events.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(host_events[0].phase))
                begin
                    e = host_events.pop_front();
                    cur_phase     <= e.phase;
                    s_axis_tuser  <= e.ev;
                    s_axis_tdata  <= {e.keys, e.data_byte};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on input words, checks output words
    always @(posedge clk)
    begin
        lksd_op_t exp_r;
        lksd_op_t act_r;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            expected_results.push_back(predict_bus_event(s_axis_tuser, s_axis_tdata[7:0],
                                                         s_axis_tdata[39:8]));
        if (m_axis_tvalid && m_axis_tready)
        begin
            act_r.read_data  = m_axis_tdata[7:0];
            act_r.ram_write  = m_axis_tdata[8];
            act_r.ram_addr   = m_axis_tdata[12:9];
            act_r.ram_data   = m_axis_tdata[20:13];
            act_r.display_on = m_axis_tdata[21];
            act_r.brightness = m_axis_tdata[24:22];
            act_r.status     = m_axis_tuser;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: result word with nothing expected: tdata %h tuser %0d",
                             $realtime, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (act_r.read_data !== exp_r.read_data ||
                    act_r.ram_write !== exp_r.ram_write ||
                    act_r.ram_addr !== exp_r.ram_addr ||
                    act_r.ram_data !== exp_r.ram_data ||
                    act_r.display_on !== exp_r.display_on ||
                    act_r.brightness !== exp_r.brightness ||
                    act_r.status !== exp_r.status ||
                    m_axis_tdata[31:25] !== 7'd0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch rd/wr/addr/data/on/lvl/st", $realtime);
                        $display("  expected %h %0d %h %h %0d %0d %0d", exp_r.read_data,
                                 exp_r.ram_write, exp_r.ram_addr, exp_r.ram_data,
                                 exp_r.display_on, exp_r.brightness, exp_r.status);
                        $display("  actual   %h %0d %h %h %0d %0d %0d pad %h",
                                 act_r.read_data, act_r.ram_write, act_r.ram_addr,
                                 act_r.ram_data, act_r.display_on, act_r.brightness,
                                 act_r.status, m_axis_tdata[31:25]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int unsigned ph;
        int unsigned n;
        logic [5:0]  r;

        // directed opening
        add_event(EV_READ,  8'h00, 32'hFFFF_FFFF, 0);   // read before any command
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'h40, 32'h0, 0);
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'hCF, 32'h0, 0);            // address 15
        add_event(EV_WRITE, 8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'hFF, 32'h0, 0);            // wraps to 0
        add_event(EV_WRITE, 8'h5A, 32'h0, 0);
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'h8F, 32'h0, 0);            // on, level 7
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'hB0, 32'h0, 0);            // off, level 0, junk bits 5..4
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'h3F, 32'h0, 0);            // unknown command
        add_event(EV_WRITE, 8'hA5, 32'h0, 0);
        add_event(EV_READ,  8'h00, 32'h0, 0);            // read in write mode
        add_event(EV_RSVD,  8'hFF, 32'hFFFF_FFFF, 0);    // reserved event code
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'h7F, 32'h8001_FF7E, 0);    // key read, other bits set
        for (int i = 0; i < 5; i++)
            add_event(EV_READ, 8'h00, 32'h0, 0);         // last one overruns
        add_event(EV_WRITE, 8'h12, 32'h0, 0);            // data byte in read mode
        add_event(EV_END,   8'h00, 32'h0, 0);
        add_event(EV_READ,  8'h00, 32'h0, 0);
        add_event(EV_WRITE, 8'hFD, 32'h0, 0);            // address 13, read mode persists
        add_event(EV_END,   8'h00, 32'h0, 0);

        // random frames
        words_made = 0;
        while (words_made < RAND_WORDS)
        begin
            ph = (words_made * 4) / RAND_WORDS;
            r  = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    add_event(EV_WRITE, {2'b01, r[5:2], 1'b0, r[0]}, $urandom(), ph);
                    add_event(EV_END, 8'($urandom_range(0, 255)), $urandom(), ph);
                end
                2, 3, 4:
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                      : $urandom_range(0, 5);
                    add_event(EV_WRITE, {2'b11, r}, $urandom(), ph);
                    for (int i = 0; i < n; i++)
                        add_event(EV_WRITE, 8'($urandom_range(0, 255)), $urandom(), ph);
                    add_event(EV_END, 8'($urandom_range(0, 255)), $urandom(), ph);
                end
                5:
                begin
                    add_event(EV_WRITE, {2'b10, r}, $urandom(), ph);
                    add_event(EV_END, 8'($urandom_range(0, 255)), $urandom(), ph);
                end
                6, 7:
                begin
                    n = $urandom_range(0, 6);
                    add_event(EV_WRITE, {2'b01, r[5:2], 1'b1, r[0]}, $urandom(), ph);
                    for (int i = 0; i < n; i++)
                        add_event(EV_READ, 8'($urandom_range(0, 255)), $urandom(), ph);
                    add_event(EV_END, 8'($urandom_range(0, 255)), $urandom(), ph);
                end
                default:
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        add_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  $urandom(), ph);
                end
            endcase
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        wait (host_events.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
